@@ sv/ple_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ple_pkg
// Shared field widths, request kinds, status codes and the cell command.
// ----------------------------------------------------------------------------
package ple_pkg;

	localparam int KIND_BITS   = 2;
	localparam int POS_BITS    = 5;
	localparam int STATUS_BITS = 2;
	localparam int FPOS_BITS   = 4;
	localparam int LEN_BITS    = 5;

	localparam logic [KIND_BITS-1:0] KIND_INSERT = 2'd0;
	localparam logic [KIND_BITS-1:0] KIND_DELETE = 2'd1;
	localparam logic [KIND_BITS-1:0] KIND_SEARCH = 2'd2;

	localparam logic [STATUS_BITS-1:0] ST_DONE  = 2'd0;
	localparam logic [STATUS_BITS-1:0] ST_RANGE = 2'd1;
	localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd2;

	// Shift command broadcast to every cell of the row.
	typedef struct packed {
		logic                ins;
		logic                del;
		logic [POS_BITS-1:0] pos;
	} cell_cmd_t;

endpackage
`default_nettype wire

@@ sv/ple_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ple_cell
// One list slot: holds an entry, shifts from a neighbor, matches a key.
// ----------------------------------------------------------------------------
module ple_cell #(
	parameter int VALUE_BITS = 32,
	parameter int INDEX      = 0
) (
	input  wire                   clk,
	input  ple_pkg::cell_cmd_t    cmd,
	input  wire  [VALUE_BITS-1:0] din,
	input  wire  [VALUE_BITS-1:0] left,
	input  wire  [VALUE_BITS-1:0] right,
	input  wire  [VALUE_BITS-1:0] key,
	output logic [VALUE_BITS-1:0] value,
	output logic                  match
);
	import ple_pkg::*;

	logic [VALUE_BITS-1:0] value_q;
	logic                  at_pos;
	logic                  after_pos;

	assign at_pos    = (32'(cmd.pos) == 32'(INDEX));
	assign after_pos = (32'(cmd.pos) < 32'(INDEX));

	always_ff @(posedge clk) begin
		if (cmd.ins && (at_pos || after_pos)) begin
			// open a gap at the insert point, later entries move back
			value_q <= at_pos ? din : left;
		end else if (cmd.del && (at_pos || after_pos)) begin
			value_q <= right;
		end
	end

	assign value = value_q;
	assign match = (value_q == key);

endmodule
`default_nettype wire

@@ sv/ple_first_match.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ple_first_match
// Registered priority encoder: lowest matching cell of the row.
// ----------------------------------------------------------------------------
module ple_first_match #(
	parameter int DEPTH = 16
) (
	input  wire                      clk,
	input  wire                      en,
	input  wire  [DEPTH-1:0]         hits,
	output logic                     found,
	output logic [$clog2(DEPTH)-1:0] index
);
	import ple_pkg::*;

	localparam int IDX_BITS = $clog2(DEPTH);

	logic                found_q;
	logic [IDX_BITS-1:0] index_q;
	logic [IDX_BITS-1:0] first;

	always_comb begin
		first = '0;
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (hits[i]) begin
				first = IDX_BITS'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			found_q <= |hits;
			index_q <= first;
		end
	end

	assign found = found_q;
	assign index = index_q;

endmodule
`default_nettype wire

@@ sv/positional_list_engine.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// positional_list_engine
// Ordered list of signed values with insert, delete and search by position.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_ group: s_tuser carries the kind (insert, delete,
//   search), s_tdata the position and the value or search key. Each request
//   gives exactly one result on the m_ group: status, found flag, first
//   matching position and the list length after the request.
//   The list lives in a row of DEPTH cells. An accepted insert or delete
//   shifts every cell past the position by one slot in the accept cycle;
//   a search compares all cells against the key in that same cycle.
//   An accepted request passes the compare stage, then the first-match
//   encoder stage, before m_tvalid. Throughput: one request per cycle while
//   the output is not stalled, set by the single cell shift per cycle; the following request sees the shifted row.
//   Reset empties the list (length zero) and clears both pipeline stages;
//   cell contents are not cleared and are never read before being written.
//   When m_tready is low the result holds; one more request is taken into
//   the compare stage, then s_tready drops until the result is taken.
// ----------------------------------------------------------------------------
module positional_list_engine #(
	parameter int DEPTH      = 16,
	parameter int VALUE_BITS = 32
) (
	input  wire                                             clk,
	input  wire                                             arst_n,
	input  wire                                             s_tvalid,
	output logic                                            s_tready,
	// bits from 0: position[4:0], value[VALUE_BITS-1:0], zero pad
	input  wire  [((ple_pkg::POS_BITS+VALUE_BITS+7)/8)*8-1:0] s_tdata,
	// bits from 0: kind[1:0]
	input  wire  [ple_pkg::KIND_BITS-1:0]                   s_tuser,
	output logic                                            m_tvalid,
	input  wire                                             m_tready,
	// bits from 0: status[1:0], found, found_position[3:0], length[4:0], pad
	output logic [15:0]                                     m_tdata
);
	import ple_pkg::*;

	localparam int CNT_BITS = $clog2(DEPTH + 1);
	localparam int IDX_BITS = $clog2(DEPTH);
	localparam int OUT_BITS = STATUS_BITS + 1 + FPOS_BITS + LEN_BITS;

	logic [CNT_BITS-1:0]    count_q;
	logic [KIND_BITS-1:0]   kind;
	logic [POS_BITS-1:0]    pos;
	logic [VALUE_BITS-1:0]  val;
	logic                   accept;
	logic                   pos_le_cnt;
	logic                   pos_lt_cnt;
	logic                   cnt_full;
	logic                   ins_ok;
	logic                   del_ok;
	logic [STATUS_BITS-1:0] status_c;
	logic [CNT_BITS-1:0]    count_next;
	cell_cmd_t              cmd;

	logic [VALUE_BITS-1:0]  cell_val [DEPTH];
	logic [DEPTH-1:0]       cell_match;
	logic [DEPTH-1:0]       hits_c;

	logic                   valid_s1;
	logic [STATUS_BITS-1:0] status_s1;
	logic [CNT_BITS-1:0]    cnt_s1;
	logic [DEPTH-1:0]       hits_s1;
	logic                   adv_s1;

	logic                   out_valid_q;
	logic [STATUS_BITS-1:0] status_q;
	logic [CNT_BITS-1:0]    cnt_q;
	logic                   found;
	logic [IDX_BITS-1:0]    found_idx;

	assign kind = s_tuser;
	assign pos  = s_tdata[POS_BITS-1:0];
	assign val  = s_tdata[POS_BITS +: VALUE_BITS];

	assign adv_s1   = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	assign pos_le_cnt = (32'(pos) <= 32'(count_q));
	assign pos_lt_cnt = (32'(pos) < 32'(count_q));
	assign cnt_full   = (32'(count_q) >= 32'(DEPTH));
	assign ins_ok     = (kind == KIND_INSERT) && pos_le_cnt && !cnt_full;
	assign del_ok     = (kind == KIND_DELETE) && pos_lt_cnt;

	always_comb begin
		status_c = ST_DONE;
		if (kind == KIND_INSERT) begin
			if (!pos_le_cnt) begin
				status_c = ST_RANGE;
			end else if (cnt_full) begin
				status_c = ST_FULL;
			end
		end else if (kind == KIND_DELETE) begin
			if (!pos_lt_cnt) begin
				status_c = ST_RANGE;
			end
		end
	end

	always_comb begin
		count_next = count_q;
		if (ins_ok) begin
			count_next = count_q + CNT_BITS'(1);
		end else if (del_ok) begin
			count_next = count_q - CNT_BITS'(1);
		end
	end

	assign cmd.ins = accept && ins_ok;
	assign cmd.del = accept && del_ok;
	assign cmd.pos = pos;

	// row of cells, each shifts from its left or right neighbor
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [VALUE_BITS-1:0] left_v;
		logic [VALUE_BITS-1:0] right_v;

		if (i == 0) begin : g_head
			assign left_v = val;
		end else begin : g_mid_l
			assign left_v = cell_val[i-1];
		end
		if (i == DEPTH - 1) begin : g_tail
			assign right_v = cell_val[i];
		end else begin : g_mid_r
			assign right_v = cell_val[i+1];
		end

		ple_cell #(
			.VALUE_BITS (VALUE_BITS),
			.INDEX      (i)
		) u_cell (
			.clk   (clk),
			.cmd   (cmd),
			.din   (val),
			.left  (left_v),
			.right (right_v),
			.key   (val),
			.value (cell_val[i]),
			.match (cell_match[i])
		);

		// only live entries count as hits, and only for a search
		assign hits_c[i] = cell_match[i] && (32'(i) < 32'(count_q)) &&
			(kind == KIND_SEARCH);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q  <= count_next;
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= status_c;
			cnt_s1    <= count_next;
			hits_s1   <= hits_c;
		end
		if (adv_s1) begin
			status_q <= status_s1;
			cnt_q    <= cnt_s1;
		end
	end

	ple_first_match #(
		.DEPTH (DEPTH)
	) u_first_match (
		.clk   (clk),
		.en    (adv_s1),
		.hits  (hits_s1),
		.found (found),
		.index (found_idx)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {(16 - OUT_BITS)'(0), LEN_BITS'(cnt_q),
		found ? FPOS_BITS'(found_idx) : FPOS_BITS'(0), found, status_q};

	// list never grows past the row of cells
	assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= 32'(DEPTH))
		else $error("list length exceeds depth");

	// an accepted insert grows the list by exactly one
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins |=> count_q == $past(count_q) + CNT_BITS'(1))
		else $error("insert did not grow the list");

	// a full status only ever reports a full list
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && status_s1 == ST_FULL) |-> 32'(cnt_s1) == 32'(DEPTH))
		else $error("full status on a list that is not full");

	// a hit is only reported with a done status
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && found) |-> status_q == ST_DONE)
		else $error("search hit with an error status");

endmodule
`default_nettype wire

@@ tb/sv/positional_list_engine_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_engine_test
// Self-checking bench for the ordered list engine.
// ----------------------------------------------------------------------------
// A directed opening hits empty and full lists, head, middle and tail inserts,
// out-of-range positions, search hit and miss, first-match on duplicates and
// the unused kind. Random phases follow that bias toward filling, draining,
// mixing or searching. A shadow of the list steers positions and keys into
// range. Each accepted request runs through a local list predictor; every
// result is compared field by field with the oldest prediction. Both sides
// insert random gaps and stalls.
// ----------------------------------------------------------------------------
module positional_list_engine_test;
	import ple_pkg::*;

	localparam int DEPTH      = 16;
	localparam int VALUE_BITS = 32;
	localparam int TDATA_BITS = ((POS_BITS + VALUE_BITS + 7) / 8) * 8;
	localparam int IDLE_LIMIT = 2000;
	localparam int RANDOM_REQUESTS = 1400;

	localparam logic [KIND_BITS-1:0] KIND_UNUSED = 2'd3;

	typedef struct {
		logic [KIND_BITS-1:0]  kind;
		logic [POS_BITS-1:0]   pos;
		logic [VALUE_BITS-1:0] val;
		bit                    drain;
	} list_request_t;

	typedef struct packed {
		logic [LEN_BITS-1:0]    length;
		logic [FPOS_BITS-1:0]   fpos;
		logic                   found;
		logic [STATUS_BITS-1:0] status;
	} list_result_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	wire                    s_tready;
	logic [TDATA_BITS-1:0]  s_tdata = '0;
	logic [KIND_BITS-1:0]   s_tuser = '0;
	wire                    m_tvalid;
	logic                   m_tready = 1'b1;
	wire  [15:0]            m_tdata;

	positional_list_engine #(
		.DEPTH(DEPTH),
		.VALUE_BITS(VALUE_BITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	list_request_t         pending_requests[$];
	list_result_t          awaited_results[$];
	logic [VALUE_BITS-1:0] plan_list[$];
	logic [VALUE_BITS-1:0] list_vals[DEPTH];
	int                    list_len = 0;
	int                    error_count = 0;

	// Predict one request against the local copy of the list.
	function automatic list_result_t apply_request(input logic [KIND_BITS-1:0] kind,
			input logic [POS_BITS-1:0] pos, input logic [VALUE_BITS-1:0] key);
		list_result_t r;
		r = '0;
		r.status = ST_DONE;
		case (kind)
			KIND_INSERT: begin
				if (int'(pos) > list_len) begin
					r.status = ST_RANGE;
				end else if (list_len >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					for (int i = list_len; i > int'(pos); i--)
						list_vals[i] = list_vals[i-1];
					list_vals[pos] = key;
					list_len++;
				end
			end
			KIND_DELETE: begin
				if (int'(pos) >= list_len) begin
					r.status = ST_RANGE;
				end else begin
					for (int i = int'(pos); i + 1 < list_len; i++)
						list_vals[i] = list_vals[i+1];
					list_len--;
				end
			end
			KIND_SEARCH: begin
				for (int i = 0; i < list_len; i++) begin
					if (!r.found && list_vals[i] == key) begin
						r.found = 1'b1;
						r.fpos  = i[FPOS_BITS-1:0];
					end
				end
			end
			default: ;
		endcase
		r.length = list_len[LEN_BITS-1:0];
		return r;
	endfunction

	// Per-request wait, with bursts where one side never idles.
	function automatic int draw_wait(inout int burst_left, inout bit lazy);
		if (burst_left == 0) begin
			burst_left = $urandom_range(10, 60);
			lazy = $urandom_range(0, 2) != 0;
		end
		burst_left--;
		if (!lazy)
			return 0;
		if ($urandom_range(0, 3) == 0)
			return $urandom_range(0, 16);
		return $urandom_range(0, 2);
	endfunction

	function automatic void check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			error_count++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endfunction

	// Queue a request and track its effect on the planned list contents.
	task automatic add_request(input logic [KIND_BITS-1:0] kind, input int pos,
			input logic [VALUE_BITS-1:0] val, input bit drain);
		list_request_t req;
		req.kind  = kind;
		req.pos   = pos[POS_BITS-1:0];
		req.val   = val;
		req.drain = drain;
		pending_requests.push_back(req);
		if (kind == KIND_INSERT && pos <= plan_list.size() && plan_list.size() < DEPTH)
			plan_list.insert(pos, val);
		else if (kind == KIND_DELETE && pos < plan_list.size())
			plan_list.delete(pos);
	endtask

	function automatic logic [VALUE_BITS-1:0] pick_value();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return $urandom_range(0, 8) - 4;
			4: return {1'b1, {(VALUE_BITS-1){1'b0}}};
			5: return {1'b0, {(VALUE_BITS-1){1'b1}}};
			default: return $urandom;
		endcase
	endfunction

	// ---- driver ----
	list_request_t staged;
	bit            staged_ok = 1'b0;
	int            gap_left = 0;
	int            send_burst = 0;
	bit            send_lazy = 1'b0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				awaited_results.push_back(apply_request(s_tuser, s_tdata[POS_BITS-1:0],
					s_tdata[POS_BITS +: VALUE_BITS]));
			if (!s_tvalid || s_tready) begin
				if (!staged_ok && pending_requests.size() > 0) begin
					staged = pending_requests.pop_front();
					staged_ok = 1'b1;
					gap_left = draw_wait(send_burst, send_lazy);
				end
				// hold a drain request until every result is back
				if (staged_ok && gap_left == 0 && (!staged.drain || awaited_results.size() == 0)) begin
					s_tvalid <= 1'b1;
					s_tdata <= TDATA_BITS'({staged.val, staged.pos});
					s_tuser <= staged.kind;
					staged_ok = 1'b0;
				end else begin
					s_tvalid <= 1'b0;
					if (staged_ok && gap_left > 0)
						gap_left--;
				end
			end
		end
	end

	// ---- monitor ----
	list_result_t want;
	int           stall_left = 0;
	int           recv_burst = 0;
	bit           recv_lazy = 1'b0;
	int           stall_draw;

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (awaited_results.size() == 0) begin
					error_count++;
					$display("%0t: unexpected result, expected none, actual 0x%04h",
						$time, m_tdata);
				end else begin
					want = awaited_results.pop_front();
					check_field("status", 32'(want.status), 32'(m_tdata[1:0]));
					check_field("found", 32'(want.found), 32'(m_tdata[2]));
					check_field("found_position", 32'(want.fpos), 32'(m_tdata[6:3]));
					check_field("length", 32'(want.length), 32'(m_tdata[11:7]));
					check_field("pad", 32'd0, 32'(m_tdata[15:12]));
				end
			end
			if (m_tready) begin
				if (m_tvalid) begin
					stall_draw = draw_wait(recv_burst, recv_lazy);
					if (stall_draw > 0) begin
						m_tready <= 1'b0;
						stall_left = stall_draw;
					end
				end
			end else begin
				if (stall_left <= 1)
					m_tready <= 1'b1;
				stall_left--;
			end
		end
	end

	// ---- watchdog ----
	int idle_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no request or result moved for %0d cycles", $time, IDLE_LIMIT);
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// ---- stimulus ----
	initial begin
		int phase;
		int phase_left;
		int roll;
		int len;
		logic [KIND_BITS-1:0]  kind;
		int                    pos;
		logic [VALUE_BITS-1:0] val;

		// empty list: miss, a delete and an insert past the end
		add_request(KIND_SEARCH, 0, 32'd5, 1'b0);
		add_request(KIND_DELETE, 0, 32'd0, 1'b0);
		add_request(KIND_INSERT, 1, 32'd9, 1'b0);
		// head, tail and middle inserts with extreme values
		add_request(KIND_INSERT, 0, 32'h7FFF_FFFF, 1'b0);
		add_request(KIND_INSERT, 1, 32'h8000_0000, 1'b0);
		add_request(KIND_INSERT, 0, 32'h0000_0000, 1'b0);
		add_request(KIND_INSERT, 2, 32'hFFFF_FFFF, 1'b0);
		add_request(KIND_SEARCH, 0, 32'h8000_0000, 1'b0);
		add_request(KIND_SEARCH, 0, 32'd5, 1'b0);
		add_request(KIND_UNUSED, 31, 32'hFFFF_FFFF, 1'b0);
		add_request(KIND_DELETE, 1, 32'd0, 1'b0);
		// fill to the top with duplicates, alternating tail and near-head
		for (int i = 0; i < 13; i++)
			add_request(KIND_INSERT, (i % 2 == 0) ? plan_list.size() : 1, i % 3, 1'b0);
		add_request(KIND_SEARCH, 0, 32'd2, 1'b0);
		add_request(KIND_INSERT, 16, 32'd77, 1'b0);
		add_request(KIND_DELETE, 16, 32'd0, 1'b0);
		add_request(KIND_DELETE, 15, 32'd0, 1'b0);

		phase = 0;
		phase_left = 0;
		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			if (phase_left == 0) begin
				phase = $urandom_range(0, 3);
				phase_left = $urandom_range(40, 120);
			end
			phase_left--;
			roll = $urandom_range(0, 99);
			case (phase)
				0: kind = roll < 70 ? KIND_INSERT : roll < 85 ? KIND_SEARCH :
					roll < 97 ? KIND_DELETE : KIND_UNUSED;
				1: kind = roll < 15 ? KIND_INSERT : roll < 35 ? KIND_SEARCH :
					roll < 97 ? KIND_DELETE : KIND_UNUSED;
				2: kind = roll < 35 ? KIND_INSERT : roll < 70 ? KIND_SEARCH :
					roll < 97 ? KIND_DELETE : KIND_UNUSED;
				default: kind = roll < 20 ? KIND_INSERT : roll < 80 ? KIND_SEARCH :
					roll < 97 ? KIND_DELETE : KIND_UNUSED;
			endcase
			len = plan_list.size();
			if ($urandom_range(0, 99) < 15)
				pos = $urandom_range(0, 16);
			else if (kind == KIND_DELETE && len > 0)
				pos = $urandom_range(0, len - 1);
			else
				pos = $urandom_range(0, len);
			val = pick_value();
			if (kind == KIND_SEARCH && len > 0 && $urandom_range(0, 99) < 65)
				val = plan_list[$urandom_range(0, len - 1)];
			add_request(kind, pos, val, n == 0 || $urandom_range(0, 199) == 0);
		end

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_requests.size() != 0 || staged_ok || s_tvalid ||
				awaited_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		if (error_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
